// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; expects aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("epc assertion failed");

// Next-cycle implication, disabled during reset.
`define EPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("epc assertion failed");

`endif

// ===== sv/epc_pkg.sv =====
// Package for the Ethernet protocol classifier: codes, offsets, payload types.
// No dependencies.
package epc_pkg;

    localparam int COUNTER_WIDTH = 32;
    localparam int NUM_COUNTERS  = 11;
    localparam int RESULT_WIDTH  = 32;

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic RESULT_FRAME   = 1'b0;
    localparam logic RESULT_COUNTER = 1'b1;

    typedef logic [5:0] offset_t;

    localparam offset_t OFS_MAX      = 6'd63;
    localparam offset_t OFS_TYPE_HI  = 6'd12;
    localparam offset_t OFS_TYPE_LO  = 6'd13;
    localparam offset_t OFS_L3_START = 6'd14;
    localparam offset_t OFS_V4_PROTO = 6'd23;
    localparam offset_t OFS_V6_NEXT  = 6'd20;
    localparam offset_t OFS_V4_PORTS = 6'd34;
    localparam offset_t OFS_V6_PORTS = 6'd54;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;

    localparam logic [7:0] IP_TCP = 8'd6;
    localparam logic [7:0] IP_UDP = 8'd17;

    localparam logic [15:0] PORT_HTTP   = 16'd80;
    localparam logic [15:0] PORT_HTTPS  = 16'd443;
    localparam logic [15:0] PORT_SMTP   = 16'd25;
    localparam logic [15:0] PORT_SMTPS  = 16'd587;
    localparam logic [15:0] PORT_FTP_D  = 16'd20;
    localparam logic [15:0] PORT_FTP_C  = 16'd21;
    localparam logic [15:0] PORT_DNS    = 16'd53;

    localparam logic [1:0] L3_OTHER = 2'd0;
    localparam logic [1:0] L3_IPV4  = 2'd1;
    localparam logic [1:0] L3_ARP   = 2'd2;
    localparam logic [1:0] L3_IPV6  = 2'd3;

    localparam logic [1:0] L4_NONE = 2'd0;
    localparam logic [1:0] L4_TCP  = 2'd1;
    localparam logic [1:0] L4_UDP  = 2'd2;

    localparam logic [2:0] APP_NONE  = 3'd0;
    localparam logic [2:0] APP_HTTP  = 3'd1;
    localparam logic [2:0] APP_HTTPS = 3'd2;
    localparam logic [2:0] APP_SMTP  = 3'd3;
    localparam logic [2:0] APP_FTP   = 3'd4;
    localparam logic [2:0] APP_DNS   = 3'd5;

    localparam int CTR_TOTAL = 0;
    localparam int CTR_IPV4  = 1;
    localparam int CTR_IPV6  = 2;
    localparam int CTR_TCP   = 3;
    localparam int CTR_UDP   = 4;
    localparam int CTR_ARP   = 5;
    localparam int CTR_DNS   = 6;
    localparam int CTR_HTTP  = 7;
    localparam int CTR_HTTPS = 8;
    localparam int CTR_FTP   = 9;
    localparam int CTR_SMTP  = 10;

    typedef logic [NUM_COUNTERS-1:0] bump_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] counter_select;
    } epc_in_t;

    typedef struct packed {
        logic                    result_kind;
        logic [1:0]              l3_class;
        logic [1:0]              l4_class;
        logic [2:0]              app_class;
        logic [RESULT_WIDTH-1:0] counter_value;
    } epc_out_t;

    // Header fields as they stand after the current byte is captured.
    typedef struct packed {
        offset_t     idx;
        logic [15:0] frame_type;
        logic [7:0]  next_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } epc_frame_t;

    typedef struct packed {
        logic [1:0] l3_class;
        logic [1:0] l4_class;
        logic [2:0] app_class;
        bump_t      bump;
    } epc_class_t;

    function automatic offset_t proto_offset(input logic [15:0] ft);
        return (ft == ETH_IPV4) ? OFS_V4_PROTO : OFS_V6_NEXT;
    endfunction

    function automatic offset_t port_base(input logic [15:0] ft);
        return (ft == ETH_IPV4) ? OFS_V4_PORTS : OFS_V6_PORTS;
    endfunction

endpackage

// ===== sv/epc_capture.sv =====
// Byte offset tracking and header field capture for one frame.
// Depends on epc_pkg.
module epc_capture (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                xfer,
    input  epc_pkg::epc_in_t    in_data,
    output epc_pkg::epc_frame_t frame
);
    import epc_pkg::*;

    offset_t     offset_reg, offset_next;
    logic [15:0] type_reg, type_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] src_reg, src_next;
    logic [15:0] dst_reg, dst_next;

    logic    known;
    offset_t base;
    offset_t need_proto;
    logic    frame_byte;

    assign frame_byte = xfer && (in_data.operation == OP_FRAME);

    always_comb begin
        type_next  = type_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (offset_reg == OFS_TYPE_HI) begin
            type_next[15:8] = in_data.data_byte;
        end
        if (offset_reg == OFS_TYPE_LO) begin
            type_next[7:0] = in_data.data_byte;
        end
        known      = (type_next == ETH_IPV4) || (type_next == ETH_IPV6);
        base       = port_base(type_next);
        need_proto = proto_offset(type_next);
        if (known && (offset_reg >= OFS_L3_START)) begin
            if (offset_reg == need_proto)     proto_next     = in_data.data_byte;
            if (offset_reg == base)           src_next[15:8] = in_data.data_byte;
            if (offset_reg == base + 6'd1)    src_next[7:0]  = in_data.data_byte;
            if (offset_reg == base + 6'd2)    dst_next[15:8] = in_data.data_byte;
            if (offset_reg == base + 6'd3)    dst_next[7:0]  = in_data.data_byte;
        end
        offset_next = (offset_reg < OFS_MAX) ? offset_reg + 6'd1 : OFS_MAX;
    end

    assign frame.idx        = offset_reg;
    assign frame.frame_type = type_next;
    assign frame.next_proto = proto_next;
    assign frame.src_port   = src_next;
    assign frame.dst_port   = dst_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            type_reg   <= '0;
            proto_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
        end else if (frame_byte) begin
            if (in_data.last_byte) begin
                offset_reg <= '0;
                type_reg   <= '0;
                proto_reg  <= '0;
                src_reg    <= '0;
                dst_reg    <= '0;
            end else begin
                offset_reg <= offset_next;
                type_reg   <= type_next;
                proto_reg  <= proto_next;
                src_reg    <= src_next;
                dst_reg    <= dst_next;
            end
        end
    end

endmodule

// ===== sv/epc_classify.sv =====
// End-of-frame classification of layer 3, layer 4 and application.
// Depends on epc_pkg.
module epc_classify (
    input  epc_pkg::epc_frame_t frame,
    output epc_pkg::epc_class_t cls
);
    import epc_pkg::*;

    function automatic logic has_port(input epc_frame_t f, input logic [15:0] p);
        return (f.src_port == p) || (f.dst_port == p);
    endfunction

    logic    is_v4;
    logic    is_v6;
    logic    ports;
    offset_t base;
    offset_t need_proto;

    always_comb begin
        is_v4      = (frame.frame_type == ETH_IPV4);
        is_v6      = (frame.frame_type == ETH_IPV6);
        base       = port_base(frame.frame_type);
        need_proto = proto_offset(frame.frame_type);
        ports      = (frame.idx >= base + 6'd3);

        cls            = '0;
        cls.bump[CTR_TOTAL] = 1'b1;
        if (frame.idx >= OFS_TYPE_LO) begin
            if (frame.frame_type == ETH_ARP) begin
                cls.l3_class      = L3_ARP;
                cls.bump[CTR_ARP] = 1'b1;
            end else if (is_v4 || is_v6) begin
                cls.l3_class       = is_v4 ? L3_IPV4 : L3_IPV6;
                cls.bump[CTR_IPV4] = is_v4;
                cls.bump[CTR_IPV6] = is_v6;
                if (frame.idx >= need_proto) begin
                    if (frame.next_proto == IP_TCP) begin
                        cls.l4_class      = L4_TCP;
                        cls.bump[CTR_TCP] = 1'b1;
                        if (ports) begin
                            if (has_port(frame, PORT_HTTP)) begin
                                cls.app_class      = APP_HTTP;
                                cls.bump[CTR_HTTP] = 1'b1;
                            end else if (has_port(frame, PORT_HTTPS)) begin
                                cls.app_class       = APP_HTTPS;
                                cls.bump[CTR_HTTPS] = 1'b1;
                            end else if (has_port(frame, PORT_SMTP) ||
                                         has_port(frame, PORT_SMTPS)) begin
                                cls.app_class      = APP_SMTP;
                                cls.bump[CTR_SMTP] = 1'b1;
                            end else if (has_port(frame, PORT_FTP_D) ||
                                         has_port(frame, PORT_FTP_C)) begin
                                cls.app_class     = APP_FTP;
                                cls.bump[CTR_FTP] = 1'b1;
                            end
                        end
                    end else if (frame.next_proto == IP_UDP) begin
                        cls.l4_class      = L4_UDP;
                        cls.bump[CTR_UDP] = 1'b1;
                        if (ports && has_port(frame, PORT_DNS)) begin
                            cls.app_class     = APP_DNS;
                            cls.bump[CTR_DNS] = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== sv/epc_counters.sv =====
// Bank of wrapping per-protocol counters with read and clear-all.
// Depends on epc_pkg.
module epc_counters (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  epc_pkg::bump_t                      bump,
    input  logic                                clear,
    input  logic [3:0]                          select,
    output logic [epc_pkg::RESULT_WIDTH-1:0]    read_value
);
    import epc_pkg::*;

    logic [COUNTER_WIDTH-1:0] count_reg [NUM_COUNTERS];
    logic [COUNTER_WIDTH-1:0] sel_value;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                if (bump[i]) begin
                    count_reg[i] <= count_reg[i] + COUNTER_WIDTH'(1);
                end
            end
        end
    end

    assign sel_value  = (select < 4'(NUM_COUNTERS)) ? count_reg[select] : '0;
    assign read_value = RESULT_WIDTH'(sel_value);

endmodule

// ===== sv/ethernet_protocol_classifier.sv =====
// Ethernet protocol classifier. Accepts one transaction per cycle: a frame byte, a counter
// read or a clear-all. The last byte of a frame and every counter read produce one result
// in the output register the cycle after acceptance; other transactions produce none.
// Throughput is one transaction per clock, limited only by m_ready: the single output
// register takes a new result whenever it is empty or being drained in the same cycle.
// Depends on epc_pkg, epc_capture, epc_classify, epc_counters.
module ethernet_protocol_classifier (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  epc_pkg::epc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output epc_pkg::epc_out_t m_data
);
    import epc_pkg::*;

    logic       xfer;
    logic       frame_end;
    logic       is_read;
    logic       produce;
    epc_frame_t frame;
    epc_class_t cls;
    bump_t      bump;
    logic [RESULT_WIDTH-1:0] read_value;

    logic     m_valid_reg, m_valid_next;
    epc_out_t m_data_reg, m_data_next;

    assign s_ready   = !m_valid_reg || m_ready;
    assign xfer      = s_valid && s_ready;
    assign frame_end = xfer && (s_data.operation == OP_FRAME) && s_data.last_byte;
    assign is_read   = xfer && (s_data.operation == OP_READ);
    assign produce   = frame_end || is_read;
    assign bump      = frame_end ? cls.bump : '0;

    epc_capture u_capture (
        .aclk    (aclk),
        .aresetn (aresetn),
        .xfer    (xfer),
        .in_data (s_data),
        .frame   (frame)
    );

    epc_classify u_classify (
        .frame (frame),
        .cls   (cls)
    );

    epc_counters u_counters (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bump       (bump),
        .clear      (xfer && (s_data.operation == OP_CLEAR)),
        .select     (s_data.counter_select),
        .read_value (read_value)
    );

    always_comb begin
        m_data_next = m_data_reg;
        if (is_read) begin
            m_data_next               = '0;
            m_data_next.result_kind   = RESULT_COUNTER;
            m_data_next.counter_value = read_value;
        end else if (frame_end) begin
            m_data_next             = '0;
            m_data_next.result_kind = RESULT_FRAME;
            m_data_next.l3_class    = cls.l3_class;
            m_data_next.l4_class    = cls.l4_class;
            m_data_next.app_class   = cls.app_class;
        end
        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/epc_checker.sv =====
// Port-level checker for the Ethernet protocol classifier, bound to the top level.
// Depends on epc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module epc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input epc_pkg::epc_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input epc_pkg::epc_out_t m_data
);
    import epc_pkg::*;

    logic count_result;
    logic frame_result;
    logic read_fields_zero;
    logic frame_fields_ok;

    assign count_result     = m_valid && (m_data.result_kind == RESULT_COUNTER);
    assign frame_result     = m_valid && (m_data.result_kind == RESULT_FRAME);
    assign read_fields_zero = (m_data.l3_class == L3_OTHER) && (m_data.l4_class == L4_NONE) &&
                              (m_data.app_class == APP_NONE);
    assign frame_fields_ok  = (m_data.counter_value == '0) &&
                              ((m_data.l4_class == L4_NONE) || (m_data.l3_class == L3_IPV4) ||
                               (m_data.l3_class == L3_IPV6)) &&
                              ((m_data.app_class == APP_NONE) || (m_data.l4_class != L4_NONE));

    `EPC_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data))
    `EPC_ASSERT_NEXT(a_input_held, s_valid && !s_ready, s_valid && $stable(s_data))
    `EPC_ASSERT_NOW(a_ready_when_empty, !m_valid || m_ready, s_ready)
    `EPC_ASSERT_NOW(a_read_no_class, count_result, read_fields_zero)
    `EPC_ASSERT_NOW(a_class_layering, frame_result, frame_fields_ok)

endmodule

bind ethernet_protocol_classifier epc_checker u_epc_checker (.*);
